### hw/rtl/dfpl_pkg.sv
// Shared constants, codes and types of the dual free page list allocator.
package dfpl_pkg;

    localparam int SMALL_PAGE_BYTES = 4096;
    localparam int HUGE_PAGE_BYTES  = 4194304;
    localparam int SMALL_PAGES      = 65536;
    localparam int HUGE_PAGES       = 1024;

    localparam int SMALL_SHIFT = $clog2(SMALL_PAGE_BYTES);
    localparam int HUGE_SHIFT  = $clog2(HUGE_PAGE_BYTES);
    localparam int SMALL_IDX_W = $clog2(SMALL_PAGES);
    localparam int HUGE_IDX_W  = $clog2(HUGE_PAGES);
    localparam int PAGE_W      = (SMALL_IDX_W > HUGE_IDX_W) ? SMALL_IDX_W : HUGE_IDX_W;

    localparam int ADDR_W         = 32;
    localparam int KIND_W         = 2;
    localparam int STATUS_W       = 2;
    localparam int SMALL_REGION_W = 29;
    localparam int HUGE_REGION_W  = 32;
    localparam int CFG_INDEX_W    = 2;
    localparam int CFG_DATA_W     = 32;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SMALL_REGION_W-1:0] SMALL_LOW_RESET  = 29'd4194304;
    localparam logic [SMALL_REGION_W-1:0] SMALL_HIGH_RESET = 29'd234881024;
    localparam logic [HUGE_REGION_W-1:0]  HUGE_LOW_RESET   = 32'd503316480;
    localparam logic [HUGE_REGION_W-1:0]  HUGE_HIGH_RESET  = 32'd1073741824;

    typedef enum logic [KIND_W-1:0] {
        KIND_FREE_SMALL  = 2'd0,
        KIND_FREE_HUGE   = 2'd1,
        KIND_ALLOC_SMALL = 2'd2,
        KIND_ALLOC_HUGE  = 2'd3
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_REJECT = 2'd2
    } status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SMALL_LOW  = 2'd0,
        REG_SMALL_HIGH = 2'd1,
        REG_HUGE_LOW   = 2'd2,
        REG_HUGE_HIGH  = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        OP_PUSH_SMALL = 3'd0,
        OP_PUSH_HUGE  = 3'd1,
        OP_POP_SMALL  = 3'd2,
        OP_POP_HUGE   = 3'd3,
        OP_REJECT     = 3'd4
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t             op;
        logic [PAGE_W-1:0]   page;
    } cmd_t;

    typedef struct packed {
        logic                   valid;
        logic [SMALL_IDX_W-1:0] page;
    } small_link_t;

    typedef struct packed {
        logic                  valid;
        logic [HUGE_IDX_W-1:0] page;
    } huge_link_t;

endpackage

### hw/rtl/dfpl_ifs.sv
// Request, response and configuration channel interfaces.
interface dfpl_req_if;
    logic                         valid;
    logic                         ready;
    logic [dfpl_pkg::KIND_W-1:0]  kind;
    logic [dfpl_pkg::ADDR_W-1:0]  page_address;

    modport source (output valid, output kind, output page_address, input ready);
    modport sink (input valid, input kind, input page_address, output ready);
endinterface

interface dfpl_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [dfpl_pkg::ADDR_W-1:0]   granted_address;
    logic [dfpl_pkg::STATUS_W-1:0] status;

    modport source (output valid, output granted_address, output status, input ready);
    modport sink (input valid, input granted_address, input status, output ready);
endinterface

interface dfpl_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [dfpl_pkg::CFG_INDEX_W-1:0] index;
    logic [dfpl_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hw/rtl/dfpl_ram.sv
// Generic single write port RAM with registered read.
module dfpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

### hw/rtl/dfpl_front.sv
// Front end: region registers and request classification into commands.
module dfpl_front (
    input  logic           clk,
    input  logic           rst_n,
    dfpl_cfg_if.sink       cfg,
    dfpl_req_if.sink       req,
    input  logic           cmd_full,
    output logic           cmd_push,
    output dfpl_pkg::cmd_t cmd
);

    logic [dfpl_pkg::SMALL_REGION_W-1:0] small_low_reg, small_low_next;
    logic [dfpl_pkg::SMALL_REGION_W-1:0] small_high_reg, small_high_next;
    logic [dfpl_pkg::HUGE_REGION_W-1:0]  huge_low_reg, huge_low_next;
    logic [dfpl_pkg::HUGE_REGION_W-1:0]  huge_high_reg, huge_high_next;

    logic [dfpl_pkg::ADDR_W-1:0] addr;
    logic                        small_ok;
    logic                        huge_ok;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        small_low_next  = small_low_reg;
        small_high_next = small_high_reg;
        huge_low_next   = huge_low_reg;
        huge_high_next  = huge_high_reg;
        if (cfg.valid)
        begin
            case (dfpl_pkg::cfg_reg_t'(cfg.index))
                dfpl_pkg::REG_SMALL_LOW:  small_low_next  = cfg.data[dfpl_pkg::SMALL_REGION_W-1:0];
                dfpl_pkg::REG_SMALL_HIGH: small_high_next = cfg.data[dfpl_pkg::SMALL_REGION_W-1:0];
                dfpl_pkg::REG_HUGE_LOW:   huge_low_next   = cfg.data[dfpl_pkg::HUGE_REGION_W-1:0];
                dfpl_pkg::REG_HUGE_HIGH:  huge_high_next  = cfg.data[dfpl_pkg::HUGE_REGION_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            small_low_reg  <= dfpl_pkg::SMALL_LOW_RESET;
            small_high_reg <= dfpl_pkg::SMALL_HIGH_RESET;
            huge_low_reg   <= dfpl_pkg::HUGE_LOW_RESET;
            huge_high_reg  <= dfpl_pkg::HUGE_HIGH_RESET;
        end
        else
        begin
            small_low_reg  <= small_low_next;
            small_high_reg <= small_high_next;
            huge_low_reg   <= huge_low_next;
            huge_high_reg  <= huge_high_next;
        end
    end

    assign addr = req.page_address;

    // aligned, inside the region, and inside the link memory
    assign small_ok = (addr[dfpl_pkg::SMALL_SHIFT-1:0] == '0)
                   && (addr >= dfpl_pkg::ADDR_W'(small_low_reg))
                   && (addr < dfpl_pkg::ADDR_W'(small_high_reg))
                   && ((addr >> dfpl_pkg::SMALL_SHIFT) < dfpl_pkg::ADDR_W'(dfpl_pkg::SMALL_PAGES));

    assign huge_ok = (addr[dfpl_pkg::HUGE_SHIFT-1:0] == '0)
                  && (addr >= dfpl_pkg::ADDR_W'(huge_low_reg))
                  && (addr < dfpl_pkg::ADDR_W'(huge_high_reg))
                  && ((addr >> dfpl_pkg::HUGE_SHIFT) < dfpl_pkg::ADDR_W'(dfpl_pkg::HUGE_PAGES));

    assign req.ready = !cmd_full;
    assign cmd_push  = req.valid && !cmd_full;

    always_comb
    begin
        cmd.op   = dfpl_pkg::OP_REJECT;
        cmd.page = '0;
        case (dfpl_pkg::kind_t'(req.kind))
            dfpl_pkg::KIND_FREE_SMALL:
            begin
                cmd.page = dfpl_pkg::PAGE_W'(addr >> dfpl_pkg::SMALL_SHIFT);
                cmd.op   = small_ok ? dfpl_pkg::OP_PUSH_SMALL : dfpl_pkg::OP_REJECT;
            end
            dfpl_pkg::KIND_FREE_HUGE:
            begin
                cmd.page = dfpl_pkg::PAGE_W'(addr >> dfpl_pkg::HUGE_SHIFT);
                cmd.op   = huge_ok ? dfpl_pkg::OP_PUSH_HUGE : dfpl_pkg::OP_REJECT;
            end
            dfpl_pkg::KIND_ALLOC_SMALL: cmd.op = dfpl_pkg::OP_POP_SMALL;
            dfpl_pkg::KIND_ALLOC_HUGE:  cmd.op = dfpl_pkg::OP_POP_HUGE;
            default: cmd.op = dfpl_pkg::OP_REJECT;
        endcase
    end

endmodule

### hw/rtl/dfpl_queue.sv
// Short command queue between the front end and the list engine.
module dfpl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  dfpl_pkg::cmd_t push_cmd,
    output logic           full,
    input  logic           pop,
    output logic           valid,
    output dfpl_pkg::cmd_t cmd
);

    dfpl_pkg::cmd_t entries_reg [dfpl_pkg::QUEUE_DEPTH];

    logic [dfpl_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [dfpl_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [dfpl_pkg::QCNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == dfpl_pkg::QCNT_W'(dfpl_pkg::QUEUE_DEPTH));
    assign valid = (count_reg != '0);
    assign cmd   = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == dfpl_pkg::QPTR_W'(dfpl_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == dfpl_pkg::QPTR_W'(dfpl_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

### hw/rtl/dfpl_back.sv
// List engine: head registers, link memories and the response register.
module dfpl_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    input  dfpl_pkg::cmd_t cmd,
    output logic           cmd_pop,
    dfpl_rsp_if.source     rsp
);

    typedef enum logic {
        BK_IDLE,
        BK_POP
    } back_state_t;

    back_state_t state_reg, state_next;

    dfpl_pkg::small_link_t small_head_reg, small_head_next;
    dfpl_pkg::huge_link_t  huge_head_reg, huge_head_next;

    logic [dfpl_pkg::ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic                        pend_huge_reg, pend_huge_next;

    logic                        rsp_valid_reg, rsp_valid_next;
    logic [dfpl_pkg::ADDR_W-1:0] rsp_addr_reg, rsp_addr_next;
    dfpl_pkg::status_t           rsp_status_reg, rsp_status_next;

    logic out_free;
    logic rsp_load;

    logic                         small_we, small_re;
    logic [dfpl_pkg::SMALL_IDX_W-1:0] small_waddr;
    logic [$bits(dfpl_pkg::small_link_t)-1:0] small_rdata;
    logic                         huge_we, huge_re;
    logic [dfpl_pkg::HUGE_IDX_W-1:0] huge_waddr;
    logic [$bits(dfpl_pkg::huge_link_t)-1:0] huge_rdata;

    assign small_waddr = cmd.page[dfpl_pkg::SMALL_IDX_W-1:0];
    assign huge_waddr  = cmd.page[dfpl_pkg::HUGE_IDX_W-1:0];

    dfpl_ram #(
        .WIDTH ($bits(dfpl_pkg::small_link_t)),
        .DEPTH (dfpl_pkg::SMALL_PAGES)
    ) u_small_links (
        .clk   (clk),
        .we    (small_we),
        .waddr (small_waddr),
        .wdata (small_head_reg),
        .re    (small_re),
        .raddr (small_head_reg.page),
        .rdata (small_rdata)
    );

    dfpl_ram #(
        .WIDTH ($bits(dfpl_pkg::huge_link_t)),
        .DEPTH (dfpl_pkg::HUGE_PAGES)
    ) u_huge_links (
        .clk   (clk),
        .we    (huge_we),
        .waddr (huge_waddr),
        .wdata (huge_head_reg),
        .re    (huge_re),
        .raddr (huge_head_reg.page),
        .rdata (huge_rdata)
    );

    assign out_free = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        state_next      = state_reg;
        small_head_next = small_head_reg;
        huge_head_next  = huge_head_reg;
        pend_addr_next  = pend_addr_reg;
        pend_huge_next  = pend_huge_reg;
        rsp_addr_next   = rsp_addr_reg;
        rsp_status_next = rsp_status_reg;
        rsp_load        = 1'b0;
        cmd_pop         = 1'b0;
        small_we        = 1'b0;
        small_re        = 1'b0;
        huge_we         = 1'b0;
        huge_re         = 1'b0;

        case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    case (cmd.op)
                        dfpl_pkg::OP_PUSH_SMALL:
                        begin
                            small_we        = 1'b1;
                            small_head_next = {1'b1, small_waddr};
                            rsp_load        = 1'b1;
                            rsp_addr_next   = '0;
                            rsp_status_next = dfpl_pkg::ST_OK;
                            cmd_pop         = 1'b1;
                        end
                        dfpl_pkg::OP_PUSH_HUGE:
                        begin
                            huge_we         = 1'b1;
                            huge_head_next  = {1'b1, huge_waddr};
                            rsp_load        = 1'b1;
                            rsp_addr_next   = '0;
                            rsp_status_next = dfpl_pkg::ST_OK;
                            cmd_pop         = 1'b1;
                        end
                        dfpl_pkg::OP_POP_SMALL:
                        begin
                            if (small_head_reg.valid)
                            begin
                                // fetch the next link; finish once it lands
                                small_re       = 1'b1;
                                pend_addr_next = dfpl_pkg::ADDR_W'(small_head_reg.page)
                                               << dfpl_pkg::SMALL_SHIFT;
                                pend_huge_next = 1'b0;
                                state_next     = BK_POP;
                            end
                            else
                            begin
                                rsp_load        = 1'b1;
                                rsp_addr_next   = '0;
                                rsp_status_next = dfpl_pkg::ST_EMPTY;
                                cmd_pop         = 1'b1;
                            end
                        end
                        dfpl_pkg::OP_POP_HUGE:
                        begin
                            if (huge_head_reg.valid)
                            begin
                                huge_re        = 1'b1;
                                pend_addr_next = dfpl_pkg::ADDR_W'(huge_head_reg.page)
                                               << dfpl_pkg::HUGE_SHIFT;
                                pend_huge_next = 1'b1;
                                state_next     = BK_POP;
                            end
                            else
                            begin
                                rsp_load        = 1'b1;
                                rsp_addr_next   = '0;
                                rsp_status_next = dfpl_pkg::ST_EMPTY;
                                cmd_pop         = 1'b1;
                            end
                        end
                        default:
                        begin
                            rsp_load        = 1'b1;
                            rsp_addr_next   = '0;
                            rsp_status_next = dfpl_pkg::ST_REJECT;
                            cmd_pop         = 1'b1;
                        end
                    endcase
                end
            end
            BK_POP:
            begin
                // link data holds until the response slot frees up
                if (out_free)
                begin
                    if (pend_huge_reg)
                    begin
                        huge_head_next = dfpl_pkg::huge_link_t'(huge_rdata);
                    end
                    else
                    begin
                        small_head_next = dfpl_pkg::small_link_t'(small_rdata);
                    end
                    rsp_load        = 1'b1;
                    rsp_addr_next   = pend_addr_reg;
                    rsp_status_next = dfpl_pkg::ST_OK;
                    cmd_pop         = 1'b1;
                    state_next      = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase

        if (rsp_load)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            small_head_reg <= '0;
            huge_head_reg  <= '0;
            pend_addr_reg  <= '0;
            pend_huge_reg  <= 1'b0;
            rsp_valid_reg  <= 1'b0;
            rsp_addr_reg   <= '0;
            rsp_status_reg <= dfpl_pkg::ST_OK;
        end
        else
        begin
            state_reg      <= state_next;
            small_head_reg <= small_head_next;
            huge_head_reg  <= huge_head_next;
            pend_addr_reg  <= pend_addr_next;
            pend_huge_reg  <= pend_huge_next;
            rsp_valid_reg  <= rsp_valid_next;
            rsp_addr_reg   <= rsp_addr_next;
            rsp_status_reg <= rsp_status_next;
        end
    end

    assign rsp.valid           = rsp_valid_reg;
    assign rsp.granted_address = rsp_addr_reg;
    assign rsp.status          = rsp_status_reg;

endmodule

### hw/rtl/dual_free_page_list_allocator.sv
// Top level of the dual free page list allocator.
//
// Requests come in on req: kind selects free small, free huge, alloc small
// or alloc huge; page_address is the page to free and is ignored for allocs.
// Every request gives exactly one response on rsp: granted_address is the
// popped page (0 for frees, empty lists and rejects) and status tells ok,
// list empty, or free rejected (misaligned, outside its region, or beyond
// the link memory). Region bounds are written over cfg, one per cycle.
// Frees, rejects and allocs from an empty list pass from the command queue
// straight into the response register. Frees and rejects sustain one
// request a cycle while rsp is ready; an alloc that finds a page also
// passes the pop state of the list engine, since the link memory read at
// the head page must return before the head moves.
// A two-entry command queue lets req keep flowing while the engine works.
// Reset empties both lists and restores default regions; link memories are
// not cleared and the block takes requests right after reset. When rsp
// stalls, the held response and the queue fill, then req.ready drops.
module dual_free_page_list_allocator (
    input  logic       clk,
    input  logic       rst_n,
    dfpl_req_if.sink   req,
    dfpl_rsp_if.source rsp,
    dfpl_cfg_if.sink   cfg
);

    logic           cmd_push;
    logic           cmd_full;
    dfpl_pkg::cmd_t push_cmd;
    logic           cmd_valid;
    logic           cmd_pop;
    dfpl_pkg::cmd_t cmd;

    dfpl_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg),
        .req      (req),
        .cmd_full (cmd_full),
        .cmd_push (cmd_push),
        .cmd      (push_cmd)
    );

    dfpl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (cmd_push),
        .push_cmd (push_cmd),
        .full     (cmd_full),
        .pop      (cmd_pop),
        .valid    (cmd_valid),
        .cmd      (cmd)
    );

    dfpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp       (rsp)
    );

    assert property (@(posedge clk) disable iff (!rst_n) cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != dfpl_pkg::ST_OK) |-> (rsp.granted_address == '0))
        else $error("failed request returned a nonzero address");

    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd_valid))
        else $error("response without a queued command");

    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |-> !cmd_full)
        else $error("request accepted into a full queue");

endmodule

### sim/dual_free_page_list_allocator_test.sv
// Self-checking testbench of the dual free page list allocator.
`timescale 1ns / 100ps

module dual_free_page_list_allocator_test;

    import dfpl_pkg::*;

    localparam int CYCLE_LIMIT     = 500000;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 10;

    // Tracks both free lists and the region registers, and holds the
    // responses still owed by the block in request order.
    class page_list_scoreboard;
        logic [SMALL_REGION_W-1:0] small_lo;
        logic [SMALL_REGION_W-1:0] small_hi;
        logic [HUGE_REGION_W-1:0]  huge_lo;
        logic [HUGE_REGION_W-1:0]  huge_hi;
        small_link_t               small_head;
        huge_link_t                huge_head;
        small_link_t               small_next [SMALL_PAGES];
        huge_link_t                huge_next [HUGE_PAGES];
        logic [ADDR_W-1:0]         grant_q [$];
        status_t                   status_q [$];
        int                        errors;
        int                        n_requests;
        int                        n_grants;
        int                        n_empty;
        int                        n_reject;
        int                        n_writes;

        function void restore_defaults();
            small_lo   = SMALL_LOW_RESET;
            small_hi   = SMALL_HIGH_RESET;
            huge_lo    = HUGE_LOW_RESET;
            huge_hi    = HUGE_HIGH_RESET;
            small_head = '0;
            huge_head  = '0;
        endfunction

        function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            n_writes++;
            case (idx)
                REG_SMALL_LOW:  small_lo = value[SMALL_REGION_W-1:0];
                REG_SMALL_HIGH: small_hi = value[SMALL_REGION_W-1:0];
                REG_HUGE_LOW:   huge_lo  = value[HUGE_REGION_W-1:0];
                REG_HUGE_HIGH:  huge_hi  = value[HUGE_REGION_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_request(kind_t op, logic [ADDR_W-1:0] addr);
            logic [ADDR_W-1:0]            grant;
            status_t                      st;
            logic [ADDR_W-SMALL_SHIFT-1:0] spage;
            logic [ADDR_W-HUGE_SHIFT-1:0]  hpage;
            grant = '0;
            st    = ST_OK;
            spage = addr[ADDR_W-1:SMALL_SHIFT];
            hpage = addr[ADDR_W-1:HUGE_SHIFT];
            n_requests++;
            case (op)
                KIND_FREE_SMALL:
                begin
                    // Page past the link memory is refused even inside the region.
                    if (addr[SMALL_SHIFT-1:0] != '0 || addr < small_lo || addr >= small_hi
                        || spage >= SMALL_PAGES)
                        st = ST_REJECT;
                    else
                    begin
                        small_next[spage[SMALL_IDX_W-1:0]] = small_head;
                        small_head = '{valid: 1'b1, page: spage[SMALL_IDX_W-1:0]};
                    end
                end
                KIND_FREE_HUGE:
                begin
                    if (addr[HUGE_SHIFT-1:0] != '0 || addr < huge_lo || addr >= huge_hi
                        || hpage >= HUGE_PAGES)
                        st = ST_REJECT;
                    else
                    begin
                        huge_next[hpage[HUGE_IDX_W-1:0]] = huge_head;
                        huge_head = '{valid: 1'b1, page: hpage[HUGE_IDX_W-1:0]};
                    end
                end
                KIND_ALLOC_SMALL:
                begin
                    if (!small_head.valid)
                        st = ST_EMPTY;
                    else
                    begin
                        grant      = ADDR_W'(small_head.page) << SMALL_SHIFT;
                        small_head = small_next[small_head.page];
                    end
                end
                default:
                begin
                    if (!huge_head.valid)
                        st = ST_EMPTY;
                    else
                    begin
                        grant     = ADDR_W'(huge_head.page) << HUGE_SHIFT;
                        huge_head = huge_next[huge_head.page];
                    end
                end
            endcase
            grant_q.push_back(grant);
            status_q.push_back(st);
        endfunction

        function void check_grant(logic [ADDR_W-1:0] got_addr, logic [STATUS_W-1:0] got_st);
            logic [ADDR_W-1:0] exp_addr;
            status_t           exp_st;
            if (grant_q.size() == 0)
            begin
                errors++;
                $display("%0t: response with no request outstanding: granted_address %h status %0d",
                         $time, got_addr, got_st);
                return;
            end
            exp_addr = grant_q.pop_front();
            exp_st   = status_q.pop_front();
            if (got_addr !== exp_addr)
            begin
                errors++;
                $display("%0t: granted_address mismatch: expected %h actual %h",
                         $time, exp_addr, got_addr);
            end
            if (got_st !== exp_st)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, exp_st, got_st);
            end
            case (exp_st)
                ST_OK:    if (exp_addr != '0) n_grants++;
                ST_EMPTY: n_empty++;
                default:  n_reject++;
            endcase
        endfunction

        function int pending();
            return grant_q.size();
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;
    bit   burst;
    bit   stall_request;
    int   cycle_count;

    page_list_scoreboard sb = new;

    dfpl_req_if req_ch ();
    dfpl_rsp_if rsp_ch ();
    dfpl_cfg_if cfg_ch ();

    dual_free_page_list_allocator u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d responses outstanding", $time, sb.pending());
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            sb.check_grant(rsp_ch.granted_address, rsp_ch.status);
    end

    // Response side: random back-pressure, with one long hold-off on demand.
    initial
    begin
        int r;
        int len;
        bit val;
        rsp_ch.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge clk);
                stall_request = 1'b0;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 55)
                begin
                    val = 1'b1;
                    len = $urandom_range(1, 4);
                end
                else if (r < 85)
                begin
                    val = 1'b0;
                    len = $urandom_range(1, 3);
                end
                else if (r < 93)
                begin
                    val = 1'b1;
                    len = $urandom_range(30, 80);
                end
                else
                begin
                    val = 1'b0;
                    len = $urandom_range(10, 40);
                end
                rsp_ch.ready <= val;
                repeat (len - 1) @(negedge clk);
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (burst || r < 62)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer(kind_t op, logic [ADDR_W-1:0] addr);
        int gap;
        @(negedge clk);
        req_ch.valid        <= 1'b1;
        req_ch.kind         <= op;
        req_ch.page_address <= addr;
        do @(posedge clk); while (!req_ch.ready);
        sb.note_request(op, addr);
        gap = pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            req_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Drop valid and wait until every owed response has come back.
    task automatic settle();
        @(negedge clk);
        req_ch.valid <= 1'b0;
        while (sb.pending() > 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.write_reg(idx, value);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic set_regions(logic [CFG_DATA_W-1:0] s_lo, logic [CFG_DATA_W-1:0] s_hi,
                               logic [CFG_DATA_W-1:0] h_lo, logic [CFG_DATA_W-1:0] h_hi);
        settle();
        write_reg(REG_SMALL_LOW, s_lo);
        write_reg(REG_SMALL_HIGH, s_hi);
        write_reg(REG_HUGE_LOW, h_lo);
        write_reg(REG_HUGE_HIGH, h_hi);
    endtask

    // Mostly pages that fit the current region, the rest near misses and noise.
    function automatic logic [ADDR_W-1:0] free_address(bit huge);
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned lo_pg;
        longint unsigned hi_pg;
        longint unsigned bytes;
        longint unsigned pg;
        int              sh;
        int              r;
        sh    = huge ? HUGE_SHIFT : SMALL_SHIFT;
        lo    = huge ? longint'(sb.huge_lo) : longint'(sb.small_lo);
        hi    = huge ? longint'(sb.huge_hi) : longint'(sb.small_hi);
        bytes = longint'(1) << sh;
        lo_pg = (lo + bytes - 1) >> sh;
        hi_pg = (hi == 0) ? 0 : (hi - 1) >> sh;
        r     = $urandom_range(0, 99);
        if (r < 78 && hi > 0 && lo_pg <= hi_pg)
        begin
            pg = lo_pg + $urandom_range(0, int'(hi_pg - lo_pg));
            return ADDR_W'(pg << sh);
        end
        else if (r < 86)
            return $urandom & ~ADDR_W'(bytes - 1);
        else if (r < 94)
        begin
            case ($urandom_range(0, 3))
                0: return ADDR_W'(lo - bytes);
                1: return ADDR_W'(hi);
                2: return ADDR_W'(lo + 1);
                default: return ADDR_W'((hi + bytes - 1) & ~(bytes - 1));
            endcase
        end
        return $urandom;
    endfunction

    task automatic run_traffic(int count, bit with_stall);
        int    r;
        kind_t op;
        for (int i = 0; i < count; i++)
        begin
            // Hold the response side off while requests keep coming back to back.
            if (with_stall && i == 40)
                stall_request = 1'b1;
            burst = with_stall && i >= 40 && i < 100;
            r = $urandom_range(0, 99);
            if (r < 40)
                op = KIND_FREE_SMALL;
            else if (r < 60)
                op = KIND_FREE_HUGE;
            else if (r < 85)
                op = KIND_ALLOC_SMALL;
            else
                op = KIND_ALLOC_HUGE;
            if (op == KIND_FREE_SMALL || op == KIND_FREE_HUGE)
                offer(op, free_address(op == KIND_FREE_HUGE));
            else
                offer(op, $urandom);
        end
        burst = 1'b0;
    endtask

    initial
    begin
        longint unsigned lo;
        longint unsigned hi;
        rst_n               = 1'b0;
        burst               = 1'b0;
        stall_request       = 1'b0;
        cycle_count         = 0;
        req_ch.valid        = 1'b0;
        req_ch.kind         = KIND_FREE_SMALL;
        req_ch.page_address = '0;
        cfg_ch.valid        = 1'b0;
        cfg_ch.index        = REG_SMALL_LOW;
        cfg_ch.data         = '0;
        sb.restore_defaults();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Default regions: empty lists, region edges, misalignment, double free.
        offer(KIND_ALLOC_SMALL, 32'hFFFF_FFFF);
        offer(KIND_ALLOC_HUGE, 32'h0000_0000);
        offer(KIND_FREE_SMALL, 32'd4194304);
        offer(KIND_FREE_SMALL, 32'd234881024 - 32'd4096);
        offer(KIND_FREE_SMALL, 32'd234881024);
        offer(KIND_FREE_SMALL, 32'd4194304 - 32'd4096);
        offer(KIND_FREE_SMALL, 32'd4194304 + 32'd1);
        offer(KIND_FREE_SMALL, 32'h0000_0000);
        offer(KIND_FREE_SMALL, 32'hFFFF_FFFF);
        offer(KIND_FREE_SMALL, 32'd4194304 + 32'd20480);
        offer(KIND_FREE_SMALL, 32'd4194304 + 32'd20480);
        repeat (5) offer(KIND_ALLOC_SMALL, $urandom);
        offer(KIND_FREE_HUGE, 32'd503316480);
        offer(KIND_FREE_HUGE, 32'd1073741824 - 32'd4194304);
        offer(KIND_FREE_HUGE, 32'd1073741824);
        offer(KIND_FREE_HUGE, 32'd503316480 + 32'd2048);
        offer(KIND_FREE_HUGE, 32'hFFC0_0000);
        repeat (3) offer(KIND_ALLOC_HUGE, $urandom);
        run_traffic(200, 1'b0);

        // Widest regions, with the long response hold-off.
        set_regions(32'd0, 32'd268435456, 32'd4194304, 32'hFFFF_FFFF);
        run_traffic(200, 1'b1);

        // Small region reaching past the link memory; a single huge page.
        set_regions(32'h0FF0_0000, 32'h1FFF_FFFF, 32'hFFC0_0000, 32'hFFFF_FFFF);
        offer(KIND_FREE_SMALL, 32'h0FFF_F000);
        offer(KIND_FREE_SMALL, 32'h1000_0000);
        offer(KIND_FREE_SMALL, 32'h1FFF_F000);
        offer(KIND_FREE_HUGE, 32'hFFC0_0000);
        offer(KIND_FREE_HUGE, 32'hFFC0_0000);
        run_traffic(150, 1'b0);

        // Inverted and empty regions refuse every free.
        set_regions(32'd268435456, 32'd0, 32'hFFFF_FFFF, 32'd4194304);
        run_traffic(50, 1'b0);
        set_regions(32'd8192, 32'd8192, 32'd8388608, 32'd8388608);
        run_traffic(50, 1'b0);

        for (int k = 0; k < 3; k++)
        begin
            lo = $urandom_range(0, 268435456 - 4096 * 64);
            hi = lo + $urandom_range(1, 4096 * 256);
            if (hi > 268435456)
                hi = 268435456;
            set_regions(32'(lo), 32'(hi), 32'd0, 32'd0);
            lo = $urandom_range(4194304, 32'hF000_0000);
            hi = lo + $urandom_range(1, 4194304 * 32);
            if (hi > 32'hFFFF_FFFF)
                hi = 32'hFFFF_FFFF;
            write_reg(REG_HUGE_LOW, 32'(lo));
            write_reg(REG_HUGE_HIGH, 32'(hi));
            run_traffic(130, 1'b0);
        end

        settle();
        $display("Covered %0d requests and %0d register writes over several region settings.",
                 sb.n_requests, sb.n_writes);
        $display("Responses: %0d pages granted, %0d empty allocs, %0d rejected frees.",
                 sb.n_grants, sb.n_empty, sb.n_reject);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
